FILE: hw/rtl/sirt_pkg.sv
package sirt_pkg;

  // Fixed field widths
  localparam int CMD_W      = 1;
  localparam int SYM_IDX_W  = 6;
  localparam int CHAR_W     = 8;
  localparam int NUM_W      = 32;
  localparam int BASE_LEN_W = 7;

  // Alphabet depth default and digit store depth
  localparam int MAX_BASE_DEF = 64;
  localparam int MAX_DIGITS   = 32;
  localparam int STACK_AW     = $clog2(MAX_DIGITS);
  localparam int DEPTH_W      = STACK_AW + 1;

  // Long division: bits of the dividend consumed per cycle
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_CYCLES = NUM_W / DIV_CHUNK;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Symbols with special meaning
  localparam logic [CHAR_W-1:0]     MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0]     PLUS_CHAR  = 8'h2B;
  localparam logic [BASE_LEN_W-1:0] MIN_RADIX  = 7'd2;
  localparam logic [BASE_LEN_W-1:0] BASE_LEN_RESET = 7'd10;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE_SYMBOL = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CONVERT      = 1'b1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_LENGTH = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [SYM_IDX_W-1:0]  symbol_index;
    logic [CHAR_W-1:0]     symbol_char;
    logic signed [NUM_W-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_SIGN,
    S_POP,
    S_LOOK,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/signed_int_to_radix_text.sv
// Write-symbol beat: stored in the alphabet memory when its index is below MAX_BASE, no output.
// Convert beat: alphabet check (one memory read per symbol; a repeated symbol or '+'/'-' drops the item),
// then the radix divider for each digit, then for each emitted byte the digit store read,
// alphabet read and output register; a negative number emits the minus sign before its digits.
// One item at a time; the next beat is taken while the final byte waits at the output.
// Reset clears the control state and sets base_length to 10; memories keep their contents.
module signed_int_to_radix_text #(
  parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  sirt_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output sirt_pkg::out_item_t                    out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sirt_pkg::PADDR_W-1:0]           paddr,
  input  logic [sirt_pkg::PDATA_W-1:0]           pwdata,
  output logic [sirt_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import sirt_pkg::*;

  localparam int ALPHA_AW = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
  localparam int DIGIT_W  = ALPHA_AW;
  localparam logic [8:0] MAX_BASE_V = 9'(MAX_BASE);

  // Memories
  logic [CHAR_W-1:0]  alphabet [MAX_BASE];
  logic [DIGIT_W-1:0] digit_stack [MAX_DIGITS];

  logic                 alpha_we;
  logic [ALPHA_AW-1:0]  alpha_waddr;
  logic                 alpha_re;
  logic [ALPHA_AW-1:0]  alpha_raddr;
  logic [CHAR_W-1:0]    alpha_rdata;
  logic                 stack_we;
  logic [STACK_AW-1:0]  stack_waddr;
  logic [DIGIT_W-1:0]   stack_wdata;
  logic                 stack_re;
  logic [STACK_AW-1:0]  stack_raddr;
  logic [DIGIT_W-1:0]   stack_rdata;

  // Control and datapath registers
  state_t                 state, state_next;
  logic [BASE_LEN_W-1:0]  base_length;
  logic                   neg;
  logic [NUM_W-1:0]       dvd;
  logic [NUM_W-1:0]       qacc;
  logic [BASE_LEN_W-1:0]  rem;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [DEPTH_W-1:0]     depth;
  logic [BASE_LEN_W-1:0]  ck_idx;
  logic                   ck_pend;
  logic [255:0]           seen;

  // Decoded conditions
  logic                   in_fire;
  logic                   is_write;
  logic                   is_conv;
  logic                   idx_in_range;
  logic                   bl_ok;
  logic                   ck_more;
  logic                   ck_bad;
  logic                   ck_done;
  logic                   div_last;
  logic                   div_more;
  logic                   out_free;
  logic                   load_out;
  logic [NUM_W-1:0]       mag_in;
  logic [NUM_W-1:0]       q_next;
  logic [BASE_LEN_W-1:0]  rem_next;
  logic                   cfg_wr;

  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign is_write     = in_fire && (in_data.command == CMD_WRITE_SYMBOL);
  assign is_conv      = in_fire && (in_data.command == CMD_CONVERT);
  assign idx_in_range = ({3'b000, in_data.symbol_index} < MAX_BASE_V);
  assign bl_ok        = (base_length >= MIN_RADIX) && ({2'b00, base_length} <= MAX_BASE_V);
  assign mag_in       = in_data.number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(in_data.number))
                                                : NUM_W'(in_data.number);

  // Alphabet check: one symbol read per cycle, each result checked in the next cycle
  assign ck_more = (ck_idx < base_length);
  assign ck_bad  = ck_pend && ((alpha_rdata == MINUS_CHAR) || (alpha_rdata == PLUS_CHAR) ||
                               seen[alpha_rdata]);
  assign ck_done = !ck_pend && !ck_more;

  // Radix divider: one chunk of dividend bits per cycle, restoring steps
  always_comb begin
    logic [BASE_LEN_W:0] r;
    logic [BASE_LEN_W:0] base_ext;
    logic [DIV_CHUNK-1:0] qb;
    base_ext = {1'b0, base_length};
    r        = {1'b0, rem};
    qb       = '0;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      r = {r[BASE_LEN_W-1:0], dvd[NUM_W-1-i]};
      if (r >= base_ext) begin
        r = r - base_ext;
        qb[DIV_CHUNK-1-i] = 1'b1;
      end
    end
    q_next   = {qacc[NUM_W-DIV_CHUNK-1:0], qb};
    rem_next = r[BASE_LEN_W-1:0];
  end

  assign div_last = (cnt == DIV_CNT_W'(DIV_CYCLES - 1));
  assign div_more = (q_next != '0) && (depth != DEPTH_W'(MAX_DIGITS - 1));

  assign out_free = !out_valid || out_ready;
  assign load_out = ((state == S_SIGN) || (state == S_EMIT)) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_conv && bl_ok) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (ck_bad) state_next = S_IDLE;
        else if (ck_done) state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_last && !div_more) state_next = neg ? S_SIGN : S_POP;
      end
      S_SIGN: begin
        if (out_free) state_next = S_POP;
      end
      S_POP:  state_next = S_LOOK;
      S_LOOK: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = (depth == '0) ? S_IDLE : S_POP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    alpha_we    = is_write && idx_in_range;
    alpha_waddr = ALPHA_AW'(in_data.symbol_index);
    alpha_re    = 1'b0;
    alpha_raddr = ALPHA_AW'(ck_idx);
    stack_we    = (state == S_DIVIDE) && div_last;
    stack_waddr = depth[STACK_AW-1:0];
    stack_wdata = DIGIT_W'(rem_next);
    stack_re    = (state == S_POP);
    stack_raddr = STACK_AW'(depth - DEPTH_W'(1));
    case (state)
      S_CHECK: alpha_re = ck_more;
      S_LOOK: begin
        alpha_re    = 1'b1;
        alpha_raddr = stack_rdata;
      end
      default: alpha_re = 1'b0;
    endcase
  end

  // Alphabet memory
  always_ff @(posedge clk) begin
    if (alpha_we) alphabet[alpha_waddr] <= in_data.symbol_char;
    if (alpha_re) alpha_rdata <= alphabet[alpha_raddr];
  end

  // Digit store
  always_ff @(posedge clk) begin
    if (stack_we) digit_stack[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata <= digit_stack[stack_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Check and divide datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (is_conv) begin
          neg     <= in_data.number[NUM_W-1];
          dvd     <= mag_in;
          qacc    <= '0;
          rem     <= '0;
          cnt     <= '0;
          depth   <= '0;
          ck_idx  <= '0;
          ck_pend <= 1'b0;
          seen    <= '0;
        end
      end
      S_CHECK: begin
        ck_pend <= ck_more;
        if (ck_more) ck_idx <= ck_idx + BASE_LEN_W'(1);
        if (ck_pend && !ck_bad) seen[alpha_rdata] <= 1'b1;
      end
      S_DIVIDE: begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (div_last) begin
          depth <= depth + DEPTH_W'(1);
          dvd   <= q_next;
          qacc  <= '0;
          rem   <= '0;
        end else begin
          dvd   <= {dvd[NUM_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}};
          qacc  <= q_next;
          rem   <= rem_next;
        end
      end
      S_POP: depth <= depth - DEPTH_W'(1);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_SIGN) begin
        out_data.out_char <= MINUS_CHAR;
        out_data.last     <= 1'b0;
      end else begin
        out_data.out_char <= alpha_rdata;
        out_data.last     <= (depth == '0);
      end
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_BASE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) base_length <= BASE_LEN_RESET;
    else if (cfg_wr) base_length <= pwdata[BASE_LEN_W-1:0];
  end

  assign prdata = (paddr[PADDR_W-1:2] == REG_BASE_LENGTH) ? PDATA_W'(base_length) : '0;

endmodule
